// ===== src/tdts_pkg.sv =====
// shared constants, codes and controller/datapath structs of the text scroller
`default_nettype none
package tdts_pkg;

  localparam int TEXT_DEPTH = 8;
  localparam int IDX_W      = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int LEN_W      = $clog2(TEXT_DEPTH + 1);

  localparam int CODE_W   = 8;
  localparam int COLOR_W  = 2;
  localparam int KIND_W   = 2;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(750);
  localparam logic [CODE_W-1:0]   DASH_RESET   = CODE_W'(64);
  localparam logic [LEN_W-1:0]    STATIC_LEN   = LEN_W'(2);

  // request kinds
  localparam logic [KIND_W-1:0] REQ_TICK = 2'd0;
  localparam logic [KIND_W-1:0] REQ_USER = 2'd1;
  localparam logic [KIND_W-1:0] REQ_SYS  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH   = 1'b1;

  typedef struct packed {
    logic capture;
    logic decode;
    logic cmp_step;
    logic copy;
    logic rd_left;
    logic rd_right;
    logic emit;
  } tdts_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_sys_end;
    logic cmp_done;
    logic out_free;
  } tdts_sts_t;

endpackage
`default_nettype wire

// ===== src/tdts_if.sv =====
// request, result and configuration channel interfaces of the text scroller
`default_nettype none
interface tdts_in_if import tdts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   req_type;
  logic [CODE_W-1:0]   segment_code;
  logic [COLOR_W-1:0]  text_color;
  logic                is_last;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, req_type, segment_code, text_color, is_last, now_ms,
                  input ready);
  modport sink   (input valid, req_type, segment_code, text_color, is_last, now_ms,
                  output ready);
endinterface

interface tdts_out_if import tdts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  left_digit;
  logic [CODE_W-1:0]  right_digit;
  logic [COLOR_W-1:0] digit_color;

  modport source (output valid, left_digit, right_digit, digit_color, input ready);
  modport sink   (input valid, left_digit, right_digit, digit_color, output ready);
endinterface

interface tdts_cfg_if import tdts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/tdts_ctrl.sv =====
// sequencing state machine of the text scroller
`default_nettype none
module tdts_ctrl import tdts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tdts_sts_t sts,
  output tdts_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_LEFT   = 3'd4;
  localparam logic [2:0] S_RIGHT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.is_sys_end) begin
          state_next = S_CMP;
        end else if (sts.is_tick) begin
          state_next = S_LEFT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts.cmp_done) begin
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy   = 1'b1;
        state_next = S_IDLE;
      end
      S_LEFT: begin
        cmd.rd_left = 1'b1;
        state_next  = S_RIGHT;
      end
      S_RIGHT: begin
        cmd.rd_right = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/tdts_dp.sv =====
// text stores, scroll state, configuration registers and result register
`default_nettype none
module tdts_dp import tdts_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tdts_cmd_t             cmd,
  output tdts_sts_t                  sts,
  input  wire logic [KIND_W-1:0]     req_type,
  input  wire logic [CODE_W-1:0]     segment_code,
  input  wire logic [COLOR_W-1:0]    text_color,
  input  wire logic                  is_last,
  input  wire logic [TIME_W-1:0]     now_ms,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CODE_W-1:0]          left_digit,
  output logic [CODE_W-1:0]          right_digit,
  output logic [COLOR_W-1:0]         digit_color
);

  logic [PERIOD_W-1:0] update_period;
  logic [CODE_W-1:0]   dash_pattern;

  logic [CODE_W-1:0] user_store    [TEXT_DEPTH];
  logic [CODE_W-1:0] staging_store [TEXT_DEPTH];
  logic [CODE_W-1:0] system_store  [TEXT_DEPTH];

  logic [LEN_W-1:0]   user_length;
  logic [LEN_W-1:0]   system_length;
  logic [LEN_W-1:0]   load_count;
  logic [IDX_W-1:0]   scroll_position;
  logic               user_showing;
  logic [COLOR_W-1:0] user_color;
  logic [COLOR_W-1:0] system_color;
  logic [TIME_W-1:0]  last_step_time;

  // captured request
  logic [KIND_W-1:0]  cap_kind;
  logic [CODE_W-1:0]  cap_code;
  logic [COLOR_W-1:0] cap_color;
  logic               cap_last;
  logic [TIME_W-1:0]  cap_now;

  // working registers
  logic [LEN_W-1:0]  text_len;
  logic [IDX_W-1:0]  cmp_idx;
  logic              differ;
  logic              due;
  logic [IDX_W-1:0]  eff_pos;
  logic [CODE_W-1:0] left_r;
  logic [CODE_W-1:0] right_r;

  logic [LEN_W-1:0]  load_next;
  logic              load_room;
  logic [TIME_W-1:0] elapsed;
  logic [LEN_W-1:0]  shown_len;
  logic [LEN_W-1:0]  pos_next;
  logic [IDX_W-1:0]  pos_next_idx;
  logic              pos_next_in;

  assign load_room    = load_count < LEN_W'(TEXT_DEPTH);
  assign load_next    = load_room ? load_count + LEN_W'(1) : LEN_W'(TEXT_DEPTH);
  assign elapsed      = cap_now - last_step_time;
  assign shown_len    = user_showing ? user_length : system_length;
  assign pos_next     = LEN_W'(eff_pos) + LEN_W'(1);
  assign pos_next_idx = pos_next[IDX_W-1:0];
  assign pos_next_in  = pos_next < shown_len;

  assign sts.is_tick    = cap_kind == REQ_TICK;
  assign sts.is_sys_end = (cap_kind == REQ_SYS) && cap_last;
  assign sts.cmp_done   = (LEN_W'(cmp_idx) + LEN_W'(1)) == text_len;
  assign sts.out_free   = !out_valid || out_ready;

  // user and staging stores hold no reset value
  always_ff @(posedge clk) begin
    if (cmd.decode && load_room) begin
      if (cap_kind == REQ_USER) begin
        user_store[load_count[IDX_W-1:0]] <= cap_code;
      end else if (cap_kind == REQ_SYS) begin
        staging_store[load_count[IDX_W-1:0]] <= cap_code;
      end
    end
  end

  // captured request and scratch values
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_code  <= segment_code;
      cap_color <= text_color;
      cap_last  <= is_last;
      cap_now   <= now_ms;
    end
    if (cmd.decode) begin
      due <= elapsed > TIME_W'(update_period);
      if (LEN_W'(scroll_position) >= shown_len) begin
        eff_pos <= '0;
      end else begin
        eff_pos <= scroll_position;
      end
      text_len <= load_next;
      cmp_idx  <= '0;
    end
    if (cmd.cmp_step) begin
      cmp_idx <= cmp_idx + IDX_W'(1);
    end
    if (cmd.rd_left) begin
      if (shown_len == '0) begin
        left_r <= dash_pattern;
      end else if (user_showing) begin
        left_r <= user_store[eff_pos];
      end else begin
        left_r <= system_store[eff_pos];
      end
    end
    if (cmd.rd_right) begin
      if (shown_len == '0) begin
        right_r <= dash_pattern;
      end else if (user_showing) begin
        right_r <= pos_next_in ? user_store[pos_next_idx] : dash_pattern;
      end else begin
        right_r <= pos_next_in ? system_store[pos_next_idx] : system_store[0];
      end
    end
    if (cmd.emit) begin
      left_digit  <= left_r;
      right_digit <= right_r;
      digit_color <= user_showing ? user_color : system_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      update_period   <= PERIOD_RESET;
      dash_pattern    <= DASH_RESET;
      for (int i = 0; i < TEXT_DEPTH; i++) begin
        system_store[i] <= '0;
      end
      user_length     <= '0;
      system_length   <= '0;
      load_count      <= '0;
      scroll_position <= '0;
      user_showing    <= 1'b0;
      user_color      <= '0;
      system_color    <= '0;
      last_step_time  <= '0;
      cap_kind        <= REQ_TICK;
      differ          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PERIOD: update_period <= cfg_data[PERIOD_W-1:0];
          CFG_DASH:   dash_pattern  <= cfg_data[CODE_W-1:0];
          default:    ;
        endcase
      end
      if (out_valid && out_ready && !cmd.emit) begin
        out_valid <= 1'b0;
      end
      if (cmd.capture) begin
        cap_kind <= req_type;
      end
      if (cmd.decode && ((cap_kind == REQ_USER) || (cap_kind == REQ_SYS))) begin
        differ <= 1'b0;
        if (!cap_last) begin
          load_count <= load_next;
        end else begin
          load_count <= '0;
          if (cap_kind == REQ_USER) begin
            user_length     <= load_next;
            user_color      <= cap_color;
            user_showing    <= 1'b1;
            scroll_position <= '0;
          end
        end
      end
      if (cmd.cmp_step && (system_store[cmp_idx] != staging_store[cmp_idx])) begin
        differ <= 1'b1;
      end
      if (cmd.copy && differ) begin
        for (int i = 0; i < TEXT_DEPTH; i++) begin
          if (LEN_W'(i) < text_len) begin
            system_store[i] <= staging_store[i];
          end
        end
        system_length   <= text_len;
        system_color    <= cap_color;
        scroll_position <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (user_showing) begin
          if (due) begin
            last_step_time <= cap_now;
            if ((user_length == '0) || !pos_next_in) begin
              user_showing    <= 1'b0;
              scroll_position <= '0;
            end else begin
              scroll_position <= pos_next_idx;
            end
          end
        end else if ((system_length != '0) && (system_length != STATIC_LEN) && due) begin
          last_step_time  <= cap_now;
          scroll_position <= pos_next_in ? pos_next_idx : '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/two_digit_text_scroller_unit.sv =====
// top level of the two-digit text scroller: channels, controller and datapath
// sequence: a code request passes through capture and decode; a system end mark
//   then compares the n staged codes one entry a cycle and copies them at once
// a refresh tick reads the left and right digits, then loads the output register once it is free
// one request at a time, set by the state machine
// reset (rst, synchronous): system store, lengths, position, colours and timer cleared,
//   update_period back to 750 and dash_pattern to 64; no clearing pass is needed
`default_nettype none
module two_digit_text_scroller_unit import tdts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  tdts_in_if.sink     in_ch,
  tdts_out_if.source  out_ch,
  tdts_cfg_if.sink    cfg
);

  tdts_cmd_t cmd;
  tdts_sts_t sts;
  logic      in_ready;

  // always taken; the user must issue writes only while the block is idle, unenforced
  assign cfg.ready   = 1'b1;
  assign in_ch.ready = in_ready;

  // sequencer: one request in flight, waits for a free output register on ticks
  tdts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, scroll state and the registered result
  tdts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (in_ch.req_type),
    .segment_code (in_ch.segment_code),
    .text_color   (in_ch.text_color),
    .is_last      (in_ch.is_last),
    .now_ms       (in_ch.now_ms),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .left_digit   (out_ch.left_digit),
    .right_digit  (out_ch.right_digit),
    .digit_color  (out_ch.digit_color)
  );

endmodule
`default_nettype wire

// ===== tb/tdts_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// display predictor and result scoreboard for the two-digit text scroller bench
package tdts_scoreboard_pkg;
  import tdts_pkg::*;

  localparam logic [KIND_W-1:0] REQ_NONE = 2'd3;
  localparam int BUF_DEPTH = TEXT_DEPTH + 4;

  typedef logic [CODE_W-1:0] text_buf_t [BUF_DEPTH];

  typedef struct packed {
    logic [CODE_W-1:0]  left_digit;
    logic [CODE_W-1:0]  right_digit;
    logic [COLOR_W-1:0] digit_color;
  } digits_t;

  class display_scoreboard;
    logic [PERIOD_W-1:0] period;
    logic [CODE_W-1:0]   dash;
    logic [CODE_W-1:0]   user_txt [TEXT_DEPTH];
    logic [CODE_W-1:0]   sys_txt  [TEXT_DEPTH];
    logic [CODE_W-1:0]   staged   [TEXT_DEPTH];
    logic [LEN_W-1:0]    user_len;
    logic [LEN_W-1:0]    sys_len;
    logic [LEN_W-1:0]    fill;
    logic [IDX_W-1:0]    pos;
    bit                  user_on;
    logic [COLOR_W-1:0]  user_col;
    logic [COLOR_W-1:0]  sys_col;
    logic [TIME_W-1:0]   last_step;
    digits_t             expected_digits [$];
    int                  errors;

    function new();
      period    = PERIOD_RESET;
      dash      = DASH_RESET;
      for (int i = 0; i < TEXT_DEPTH; i++) begin
        user_txt[i] = '0;
        sys_txt[i]  = '0;
        staged[i]   = '0;
      end
      user_len  = '0;
      sys_len   = '0;
      fill      = '0;
      pos       = '0;
      user_on   = 1'b0;
      user_col  = '0;
      sys_col   = '0;
      last_step = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PERIOD) period = data[PERIOD_W-1:0];
      else if (idx == CFG_DASH) dash = data[CODE_W-1:0];
    endfunction

    // one text code; the end mark commits it
    function void load_code(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                            logic [COLOR_W-1:0] color, logic last);
      int n;
      bit differ;
      if (fill < TEXT_DEPTH) begin
        if (kind == REQ_USER) user_txt[fill] = code;
        else staged[fill] = code;
      end
      n = (fill < TEXT_DEPTH) ? int'(fill) + 1 : TEXT_DEPTH;
      if (!last) begin
        fill = LEN_W'(n);
        return;
      end
      fill = '0;
      if (kind == REQ_USER) begin
        user_len = LEN_W'(n);
        user_col = color;
        user_on  = 1'b1;
        pos      = '0;
        return;
      end
      differ = 1'b0;
      for (int i = 0; i < n; i++)
        if (sys_txt[i] !== staged[i]) differ = 1'b1;
      if (differ) begin
        for (int i = 0; i < n; i++) sys_txt[i] = staged[i];
        sys_len = LEN_W'(n);
        sys_col = color;
        pos     = '0;
      end
    endfunction

    function digits_t predict_display(logic [TIME_W-1:0] now);
      digits_t          d;
      logic [TIME_W-1:0] elapsed;
      bit               due;
      int               p;
      elapsed = now - last_step;
      due = elapsed > TIME_W'(period);
      d.left_digit  = dash;
      d.right_digit = dash;
      p = int'(pos);
      if (user_on) begin
        d.digit_color = user_col;
        if (p >= user_len) p = 0;
        if (user_len > 0) begin
          d.left_digit = user_txt[p];
          if (p + 1 < user_len) d.right_digit = user_txt[p + 1];
        end
        if (due) begin
          last_step = now;
          if (user_len == 0 || p + 1 >= user_len) begin
            user_on = 1'b0;
            pos     = '0;
          end else begin
            pos = IDX_W'(p + 1);
          end
        end
      end else begin
        d.digit_color = sys_col;
        if (p >= sys_len) p = 0;
        if (sys_len > 0) begin
          d.left_digit  = sys_txt[p];
          d.right_digit = (p + 1 < sys_len) ? sys_txt[p + 1] : sys_txt[0];
          if (sys_len != STATIC_LEN && due) begin
            last_step = now;
            pos = (p + 1 < sys_len) ? IDX_W'(p + 1) : '0;
          end
        end
      end
      return d;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                               logic [COLOR_W-1:0] color, logic last,
                               logic [TIME_W-1:0] now);
      if (kind == REQ_USER || kind == REQ_SYS) load_code(kind, code, color, last);
      else if (kind == REQ_TICK) expected_digits.push_back(predict_display(now));
    endfunction

    function void check_digits(logic [CODE_W-1:0] left_d, logic [CODE_W-1:0] right_d,
                               logic [COLOR_W-1:0] color);
      digits_t want;
      if (expected_digits.size() == 0) begin
        $error("display update with none outstanding: %02h %02h colour %0d",
               left_d, right_d, color);
        errors++;
        return;
      end
      want = expected_digits.pop_front();
      if (left_d !== want.left_digit) begin
        $error("left_digit expected %02h got %02h", want.left_digit, left_d);
        errors++;
      end
      if (right_d !== want.right_digit) begin
        $error("right_digit expected %02h got %02h", want.right_digit, right_d);
        errors++;
      end
      if (color !== want.digit_color) begin
        $error("digit_color expected %0d got %0d", want.digit_color, color);
        errors++;
      end
    endfunction

    function void check_drained();
      if (expected_digits.size() != 0) begin
        $error("%0d display updates never arrived", expected_digits.size());
        errors += expected_digits.size();
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// top-level bench of the two-digit text scroller: stimulus, handshakes and checking
module tb_top;
  import tdts_pkg::*;
  import tdts_scoreboard_pkg::*;

  localparam int  CYCLE_LIMIT   = 600000;
  // a system end mark compares up to eight entries, so give loads time to finish
  localparam int  SETTLE_CYCLES = 24;
  localparam int  PHASE_ITEMS   = 400;
  localparam int  NUM_PHASES    = 5;

  // register settings per phase, extremes included
  localparam logic [PERIOD_W-1:0] PHASE_PERIOD [NUM_PHASES] = '{16'd0, 16'd65535, 16'd3,
                                                                16'd750, 16'd40};
  localparam logic [CODE_W-1:0]   PHASE_DASH   [NUM_PHASES] = '{8'h00, 8'hFF, 8'h5A,
                                                                8'hA5, 8'h40};

  logic clk;
  logic rst;

  tdts_in_if  in_ch ();
  tdts_out_if out_ch ();
  tdts_cfg_if cfg_ch ();

  two_digit_text_scroller_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  display_scoreboard sb = new();

  int                items_sent;
  bit                tx_steady;
  bit                rx_steady;
  int                rx_wait;
  int                cycles;
  logic [TIME_W-1:0] clock_ms;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // per-item wait, now and then switching into a stretch with no idling at all
  function automatic int draw_wait(inout bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[two_digit_text_scroller_unit] ERROR");
      $finish;
    end
  end

  // result side: check on each accepted display update, then stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_digits(out_ch.left_digit, out_ch.right_digit, out_ch.digit_color);
        rx_wait = draw_wait(rx_steady);
      end
      if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one request on the input channel; returns at the edge that accepts it,
  // leaving valid high so a back-to-back request needs no extra assignment
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                              input logic [COLOR_W-1:0] color, input logic last,
                              input logic [TIME_W-1:0] now);
    int gap;
    gap = draw_wait(tx_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= kind;
    in_ch.segment_code <= code;
    in_ch.text_color   <= color;
    in_ch.is_last      <= last;
    in_ch.now_ms       <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(kind, code, color, last, now);
    if (kind != REQ_NONE) items_sent++;
  endtask

  // refresh tick: mostly a steady clock, some ticks right on the step boundary,
  // a few wild jumps so the elapsed time wraps and goes backwards
  task automatic send_tick();
    logic [TIME_W-1:0] now;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      now = $urandom();
    else if (pick < 20)
      now = sb.last_step + TIME_W'(sb.period) + TIME_W'($urandom_range(0, 1));
    else
      now = clock_ms + TIME_W'($urandom_range(0, int'(sb.period) / 2 + 2));
    clock_ms = now;
    send_request(REQ_TICK, CODE_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), now);
  endtask

  // whole text; stray codes of the other kind only land past the store depth,
  // where they are dropped, so no unwritten entry is ever read back
  task automatic send_text(input logic [KIND_W-1:0] kind, input text_buf_t codes,
                           input int len, input logic [COLOR_W-1:0] color,
                           input bit stray, input bit scatter);
    logic [KIND_W-1:0] k;
    logic              end_mark;
    for (int i = 0; i < len; i++) begin
      if (scatter) begin
        if ($urandom_range(0, 5) == 0) send_tick();
        if ($urandom_range(0, 19) == 0)
          send_request(REQ_NONE, CODE_W'($urandom()), COLOR_W'($urandom()), 1'($urandom()),
                       $urandom());
      end
      k = kind;
      if (stray && i >= TEXT_DEPTH && i != len - 1)
        k = (kind == REQ_USER) ? REQ_SYS : REQ_USER;
      end_mark = (i == len - 1);
      send_request(k, codes[i], end_mark ? color : COLOR_W'($urandom_range(0, 3)),
                   end_mark, $urandom());
    end
  endtask

  task automatic send_random_text(input logic [KIND_W-1:0] kind);
    text_buf_t codes;
    int        len;
    int        span;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(TEXT_DEPTH + 1, BUF_DEPTH - 1)
                                      : $urandom_range(1, TEXT_DEPTH);
    if (kind == REQ_SYS && $urandom_range(0, 3) == 0) len = 2;
    for (int i = 0; i < BUF_DEPTH; i++) codes[i] = CODE_W'($urandom_range(0, 255));
    // resend what is stored, sometimes with one code altered
    if (kind == REQ_SYS && $urandom_range(0, 2) == 0) begin
      for (int i = 0; i < TEXT_DEPTH; i++) codes[i] = sb.sys_txt[i];
      if ($urandom_range(0, 1) == 1) begin
        span = (len < TEXT_DEPTH) ? len : TEXT_DEPTH;
        codes[$urandom_range(0, span - 1)] ^= CODE_W'($urandom_range(1, 255));
      end
    end
    send_text(kind, codes, len, COLOR_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // hold the request side until every display update has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_digits.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // directed opening at the reset settings
  task automatic run_directed();
    text_buf_t codes;
    // empty system text shows dashes, and a due tick does not step it
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'd0);
    send_request(REQ_TICK, 8'hFF, 2'd3, 1'b1, 32'd751);
    codes = '{default: 8'h00};
    codes[0] = 8'hFF;
    send_text(REQ_SYS, codes, 1, 2'd3, 1'b0, 1'b0);
    // one-code system text: right digit wraps to the same entry
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'hFFFF_FFFF);
    codes[0] = 8'h00;
    codes[1] = 8'h80;
    send_text(REQ_SYS, codes, 2, 2'd2, 1'b0, 1'b0);
    // elapsed time wraps to one, nothing due
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'd0);
    // identical system text is not taken, colour stays
    send_text(REQ_SYS, codes, 2, 2'd1, 1'b0, 1'b0);
    // two-code system text stays static even when due
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'h0000_1000);
    codes[0] = 8'h01;
    codes[1] = 8'h7F;
    codes[2] = 8'hFE;
    send_text(REQ_USER, codes, 3, 2'd1, 1'b0, 1'b0);
    // user text scrolls once, dash past its end, then back to system text
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'h0000_3000);
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'h0000_4000);
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'h0000_5000);
    // unknown request code is ignored
    send_request(REQ_NONE, 8'hAA, 2'd2, 1'b1, 32'h5555_AAAA);
    // overlong system text with a stray user code past the depth
    for (int i = 0; i < BUF_DEPTH; i++) codes[i] = CODE_W'(8'h11 * (i + 1));
    send_text(REQ_SYS, codes, TEXT_DEPTH + 2, 2'd0, 1'b1, 1'b0);
    send_request(REQ_TICK, 8'h00, 2'd0, 1'b0, 32'h0000_7000);
  endtask

  task automatic run_phase(input int target);
    int  first;
    int  pick;
    bit  paused;
    first  = items_sent;
    paused = 1'b0;
    while (items_sent - first < target) begin
      // one full drain in the middle of each phase
      if (!paused && items_sent - first >= target / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) send_tick();
      else if (pick < 75) send_random_text(REQ_USER);
      else if (pick < 95) send_random_text(REQ_SYS);
      else send_request(REQ_NONE, CODE_W'($urandom()), COLOR_W'($urandom()), 1'($urandom()),
                        $urandom());
    end
  endtask

  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_TICK;
    in_ch.segment_code = '0;
    in_ch.text_color   = '0;
    in_ch.is_last      = 1'b0;
    in_ch.now_ms       = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_PERIOD;
    cfg_ch.data        = '0;
    items_sent         = 0;
    tx_steady          = 1'b0;
    rx_steady          = 1'b0;
    cycles             = 0;
    clock_ms           = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(CFG_PERIOD, CFG_DATA_W'(PHASE_PERIOD[ph]));
      // upper byte of the dash write is don't-care, so make it noise
      write_reg(CFG_DASH, {8'($urandom_range(0, 255)), PHASE_DASH[ph]});
      clock_ms = sb.last_step;
      run_phase(PHASE_ITEMS);
    end

    settle();
    sb.check_drained();
    if (sb.errors == 0)
      $display("[two_digit_text_scroller_unit] OK");
    else
      $display("[two_digit_text_scroller_unit] ERROR");
    $finish;
  end

endmodule
